// ===== hdl/wels_pkg.sv =====
// Shared constants, codes and request types for the weighted edge list store.
// Used by every module of the block but wels_ram; depends on nothing else.
`default_nettype none

package wels_pkg;

  // Sizes of the graph and of the fields.
  localparam int unsigned VERTICES         = 128;
  localparam int unsigned EDGES_PER_VERTEX = 16;
  localparam int unsigned VTX_W            = 7;
  localparam int unsigned WEIGHT_W         = 32;
  localparam int unsigned ACTION_W         = 2;
  localparam int unsigned STATUS_W         = 2;

  // Derived widths of the stores.
  localparam int unsigned VIDX_W      = $clog2(VERTICES);
  localparam int unsigned CNT_W       = $clog2(EDGES_PER_VERTEX + 1);
  localparam int unsigned SLOT_TOTAL  = VERTICES * EDGES_PER_VERTEX;
  localparam int unsigned ADDR_W      = $clog2(SLOT_TOTAL);
  localparam int unsigned SLOT_DATA_W = VTX_W + WEIGHT_W;

  // Reset value of the vertex limit register.
  localparam logic [VTX_W-1:0] MAX_VERTEX_RESET = VTX_W'(100);

  // Request codes.
  localparam logic [ACTION_W-1:0] ACT_ADD    = ACTION_W'(0);
  localparam logic [ACTION_W-1:0] ACT_MODIFY = ACTION_W'(1);
  localparam logic [ACTION_W-1:0] ACT_DELETE = ACTION_W'(2);

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // One slot of an edge list.
  typedef struct packed {
    logic [VTX_W-1:0]    dst;
    logic [WEIGHT_W-1:0] wt;
  } slot_t;

  // Access to the slot memory: one write and one read port.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    slot_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } slot_req_t;

  // Access to the per-vertex count store.
  typedef struct packed {
    logic              we;
    logic [VIDX_W-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic [VIDX_W-1:0] raddr;
  } cnt_req_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic    valid;
    status_e status;
  } resp_t;

endpackage

`default_nettype wire

// ===== hdl/wels_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; holds the slots of every edge list.
`default_nettype none

module wels_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 39
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read in the same cycle; the read returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/wels_cnt_store.sv =====
// Per-vertex edge count store: a memory with one valid bit per entry.
// Depends on wels_pkg. An entry not written since reset reads as zero.
`default_nettype none

module wels_cnt_store (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire wels_pkg::cnt_req_t       req_i,
  output      logic [wels_pkg::CNT_W-1:0] rdata_o
);
  import wels_pkg::*;

  logic [CNT_W-1:0]    mem [VERTICES];
  logic [CNT_W-1:0]    rdata_q;
  logic [VERTICES-1:0] valid_q;
  logic                rd_valid_q;

  // Count memory, read data registered.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  // Valid bits, cleared at once by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rd_valid_q <= valid_q[req_i.raddr];
    end
  end

  assign rdata_o = rd_valid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== hdl/wels_seq.sv =====
// Request sequencer: reads the list count, appends an entry on an add, scans the
// list for a match and shifts entries down on a delete. Depends on wels_pkg.
`default_nettype none

module wels_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [wels_pkg::ACTION_W-1:0] action_i,
  input  wire logic [wels_pkg::VTX_W-1:0]    from_vertex_i,
  input  wire logic [wels_pkg::VTX_W-1:0]    to_vertex_i,
  input  wire logic [wels_pkg::WEIGHT_W-1:0] edge_weight_i,
  input  wire logic [wels_pkg::WEIGHT_W-1:0] replacement_weight_i,
  input  wire logic [wels_pkg::VTX_W-1:0]    max_vertex_i,
  input  wire logic [wels_pkg::CNT_W-1:0]    cnt_rdata_i,
  input  wire wels_pkg::slot_t               slot_rdata_i,
  output      wels_pkg::cnt_req_t            cnt_req_o,
  output      wels_pkg::slot_req_t           slot_req_o,
  input  wire logic                          out_free_i,
  output      wels_pkg::resp_t               resp_o
);
  import wels_pkg::*;

  localparam int unsigned IW = CNT_W + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_COUNT   = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_SHIFT   = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;
  localparam logic [2:0] S_RESPOND = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [ACTION_W-1:0] act_q, act_d;
  logic [VTX_W-1:0]    src_q, src_d;
  logic [VTX_W-1:0]    dst_q, dst_d;
  logic [WEIGHT_W-1:0] w_q, w_d;
  logic [WEIGHT_W-1:0] nw_q, nw_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  status_e             status_q, status_d;

  logic [IW-1:0] idx_p1;
  logic [IW-1:0] idx_p2;
  logic [IW-1:0] n_ext;
  logic          src_ok;
  logic          hit;

  assign idx_p1 = IW'(idx_q) + IW'(1);
  assign idx_p2 = IW'(idx_q) + IW'(2);
  assign n_ext  = IW'(n_q);
  assign src_ok = (32'(src_q) <= 32'(max_vertex_i)) && (32'(src_q) < VERTICES);
  assign hit    = (slot_rdata_i.dst == dst_q) && (slot_rdata_i.wt == w_q);

  assign in_ready_o = (state_q == S_IDLE);

  // Next-state and memory access logic.
  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    src_d    = src_q;
    dst_d    = dst_q;
    w_d      = w_q;
    nw_d     = nw_q;
    base_d   = base_q;
    n_d      = n_q;
    idx_d    = idx_q;
    status_d = status_q;

    slot_req_o.we    = 1'b0;
    slot_req_o.waddr = ADDR_W'(base_q + ADDR_W'(idx_q));
    slot_req_o.wdata = slot_rdata_i;
    slot_req_o.raddr = ADDR_W'(base_q + ADDR_W'(idx_p1));

    cnt_req_o.we    = 1'b0;
    cnt_req_o.waddr = VIDX_W'(src_q);
    cnt_req_o.wdata = CNT_W'(n_q - CNT_W'(1));
    cnt_req_o.raddr = VIDX_W'(from_vertex_i);

    resp_o.valid  = 1'b0;
    resp_o.status = status_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          src_d   = from_vertex_i;
          dst_d   = to_vertex_i;
          w_d     = edge_weight_i;
          nw_d    = replacement_weight_i;
          base_d  = ADDR_W'(ADDR_W'(from_vertex_i) * ADDR_W'(EDGES_PER_VERTEX));
          state_d = S_COUNT;
        end
      end

      // The list count has arrived; decide what the request needs.
      S_COUNT: begin
        n_d      = cnt_rdata_i;
        status_d = STATUS_MISS;
        state_d  = S_RESPOND;
        if (src_ok) begin
          case (act_q)
            ACT_ADD: begin
              if (32'(dst_q) > 32'(max_vertex_i)) begin
                status_d = STATUS_MISS;
              end else if (32'(cnt_rdata_i) >= EDGES_PER_VERTEX) begin
                status_d = STATUS_FULL;
              end else begin
                slot_req_o.we        = 1'b1;
                slot_req_o.waddr     = ADDR_W'(base_q + ADDR_W'(cnt_rdata_i));
                slot_req_o.wdata.dst = dst_q;
                slot_req_o.wdata.wt  = w_q;
                cnt_req_o.we         = 1'b1;
                cnt_req_o.wdata      = CNT_W'(cnt_rdata_i + CNT_W'(1));
                status_d             = STATUS_OK;
              end
            end
            ACT_MODIFY, ACT_DELETE: begin
              if (cnt_rdata_i != '0) begin
                slot_req_o.raddr = base_q;
                idx_d            = '0;
                state_d          = S_SCAN;
              end
            end
            default: begin
              status_d = STATUS_MISS;
            end
          endcase
        end
      end

      // Slot idx_q is on the read port; the next slot is fetched ahead.
      S_SCAN: begin
        if (hit) begin
          if (act_q == ACT_MODIFY) begin
            slot_req_o.we       = 1'b1;
            slot_req_o.wdata.wt = nw_q;
            status_d            = STATUS_OK;
            state_d             = S_RESPOND;
          end else if (idx_p1 < n_ext) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_FINISH;
          end
        end else if (idx_p1 >= n_ext) begin
          status_d = STATUS_MISS;
          state_d  = S_RESPOND;
        end else begin
          idx_d = CNT_W'(idx_p1);
        end
      end

      // Slot idx_q+1 is on the read port and moves down to idx_q.
      S_SHIFT: begin
        slot_req_o.we    = 1'b1;
        slot_req_o.raddr = ADDR_W'(base_q + ADDR_W'(idx_p2));
        idx_d            = CNT_W'(idx_p1);
        if (idx_p2 >= n_ext) begin
          state_d = S_FINISH;
        end
      end

      // The delete is complete: one entry fewer.
      S_FINISH: begin
        cnt_req_o.we = 1'b1;
        status_d     = STATUS_OK;
        state_d      = S_RESPOND;
      end

      // Hand the status over once the output register can take it.
      S_RESPOND: begin
        if (out_free_i) begin
          resp_o.valid = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request fields and working registers.
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    w_q      <= w_d;
    nw_q     <= nw_d;
    base_q   <= base_d;
    n_q      <= n_d;
    idx_q    <= idx_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire

// ===== hdl/weighted_edge_list_store_unit.sv =====
// Top level of the weighted edge list store: limit register, output register,
// slot memory, count store and sequencer. Depends on wels_pkg and all wels_ modules.
//
// Usage:
//   Requests arrive on the in_ channel (valid/ready); each transfer carries an
//   action (add, modify, delete), a source and destination vertex and two
//   weights. Every request yields exactly one status transfer on the out_
//   channel: success, not found / vertex out of range, or list full.
//   One request is worked on at a time. An add or a rejected request needs only
//   the count read; a modify or a failed search also reads the list entries one
//   by one up to a match, and a delete then shifts the entries behind the match
//   down and writes the count back (16 slots per list). The next request is
//   taken once the status has been handed to the output register. The pace is
//   set by the single read port of the slot memory: the match scan reads one
//   slot a cycle, and the shift moves one slot a cycle.
//   The status waits in an output register, so a new request is taken while
//   the receiver stalls; the sequencer holds its next status until the
//   register is free.
//   Reset empties every list and sets the vertex limit to 100; it needs no
//   clearing pass. The limit is written through cfg_we_i/cfg_wdata_i; the user
//   must do so only while the block is idle, which the block does not enforce.
`default_nettype none

module weighted_edge_list_store_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wels_pkg::VTX_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [wels_pkg::ACTION_W-1:0] action_i,
  input  wire logic [wels_pkg::VTX_W-1:0]    from_vertex_i,
  input  wire logic [wels_pkg::VTX_W-1:0]    to_vertex_i,
  input  wire logic signed [wels_pkg::WEIGHT_W-1:0] edge_weight_i,
  input  wire logic signed [wels_pkg::WEIGHT_W-1:0] replacement_weight_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [wels_pkg::STATUS_W-1:0] status_o
);
  import wels_pkg::*;

  logic [VTX_W-1:0]       max_vertex_q;
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic                   out_free;
  cnt_req_t               cnt_req;
  slot_req_t              slot_req;
  logic [CNT_W-1:0]       cnt_rdata;
  logic [SLOT_DATA_W-1:0] slot_rdata;
  resp_t                  resp;

  // Vertex limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vertex_q <= MAX_VERTEX_RESET;
    end else if (cfg_we_i) begin
      max_vertex_q <= cfg_wdata_i;
    end
  end

  // Output register: loaded when a status is finished, freed by a transfer.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp.valid) begin
      status_q <= STATUS_W'(resp.status);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  // Slots of every edge list.
  wels_ram #(
    .DEPTH(SLOT_TOTAL),
    .WIDTH(SLOT_DATA_W)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_req.we),
    .waddr_i(slot_req.waddr),
    .wdata_i(slot_req.wdata),
    .raddr_i(slot_req.raddr),
    .rdata_o(slot_rdata)
  );

  // Entries in each list.
  wels_cnt_store u_cnt_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cnt_req),
    .rdata_o(cnt_rdata)
  );

  // Request sequencer.
  wels_seq u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .from_vertex_i       (from_vertex_i),
    .to_vertex_i         (to_vertex_i),
    .edge_weight_i       (edge_weight_i),
    .replacement_weight_i(replacement_weight_i),
    .max_vertex_i        (max_vertex_q),
    .cnt_rdata_i         (cnt_rdata),
    .slot_rdata_i        (slot_t'(slot_rdata)),
    .cnt_req_o           (cnt_req),
    .slot_req_o          (slot_req),
    .out_free_i          (out_free),
    .resp_o              (resp)
  );

`ifndef NO_ASSERTIONS
  // One request at a time: after a transfer the input side closes.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while another was in flight");

  // A list count written back never exceeds the slots of a list.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_req.we |-> (32'(cnt_req.wdata) <= EDGES_PER_VERTEX))
    else $error("edge count written beyond the list size");

  // The slot memory is only written while a request is being worked on.
  a_slot_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_req.we |-> !in_ready_o)
    else $error("slot write while idle");

  // A finished status is only handed over when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !resp.valid)
    else $error("status overwritten before its transfer");
`endif

endmodule

`default_nettype wire
